FILE: rtl/regex_dot_star_matcher_unit_macros.svh
// ----------------------------------------------------------------------------
// regex dot-star matcher assertion macros
// clocked concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef REGEX_DOT_STAR_MATCHER_UNIT_MACROS_SVH
`define REGEX_DOT_STAR_MATCHER_UNIT_MACROS_SVH

`ifndef SYNTH

// property must hold at every edge out of reset
`define RDSM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RDSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define RDSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define RDSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/rdsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsm_pkg
// shared constants, types and helpers of the regex dot-star matcher
// ----------------------------------------------------------------------------
package rdsm_pkg;

  localparam int MAX_PATTERN = 32;

  localparam logic [7:0] SYM_STAR = 8'h2A;
  localparam logic [7:0] SYM_ANY  = 8'h2E;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEXT   = 2'd2,
    ACT_END    = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_CLOSE
  } state_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic capture;
    logic step;
    logic text;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic stable;
    logic out_free;
  } dp_status_t;

  function automatic logic sym_hits(input logic [7:0] pat, input logic [7:0] b);
    return (pat == SYM_ANY) || (pat == b);
  endfunction

endpackage

FILE: rtl/rdsm_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsm channels
// valid/ready request channels for input items and results
// ----------------------------------------------------------------------------
interface rdsm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] symbol;

  modport source (output valid, output action, output symbol, input ready);
  modport sink (input valid, input action, input symbol, output ready);
endinterface

interface rdsm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic bad_pattern;

  modport source (output valid, output matched, output bad_pattern, input ready);
  modport sink (input valid, input matched, input bad_pattern, output ready);
endinterface

FILE: rtl/rdsm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsm_ctrl
// sequencer: takes requests, runs closure passes, issues datapath commands
// ----------------------------------------------------------------------------
module rdsm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_action,
  output logic                  in_ready,
  input  rdsm_pkg::dp_status_t  status,
  output rdsm_pkg::dp_cmd_t     cmd
);

  rdsm_pkg::state_t  state_r, state_nxt;
  logic              pend_end_r, pend_end_nxt;
  rdsm_pkg::action_t act;

  assign act = rdsm_pkg::action_t'(in_action);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rdsm_pkg::ST_IDLE;
      pend_end_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_end_r <= pend_end_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    pend_end_nxt = pend_end_r;
    unique case (state_r)
      rdsm_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (act)
            rdsm_pkg::ACT_TEXT, rdsm_pkg::ACT_END: begin
              state_nxt    = rdsm_pkg::ST_CLOSE;
              pend_end_nxt = (act == rdsm_pkg::ACT_END);
            end
            default: ;
          endcase
        end
      end
      rdsm_pkg::ST_CLOSE: begin
        if (status.stable && (!pend_end_r || status.out_free)) begin
          state_nxt = rdsm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rdsm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      rdsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (act)
            rdsm_pkg::ACT_CLEAR:  cmd.clear   = 1'b1;
            rdsm_pkg::ACT_APPEND: cmd.append  = 1'b1;
            rdsm_pkg::ACT_TEXT, rdsm_pkg::ACT_END: cmd.capture = 1'b1;
            default: ;
          endcase
        end
      end
      rdsm_pkg::ST_CLOSE: begin
        if (!status.stable) begin
          cmd.step = 1'b1;
        end else if (!pend_end_r) begin
          cmd.text = 1'b1;
        end else if (status.out_free) begin
          cmd.finish = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/rdsm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsm_datapath
// pattern store, match row with closure and byte update, result register
// ----------------------------------------------------------------------------
module rdsm_datapath #(
  parameter int MaxPattern = rdsm_pkg::MAX_PATTERN
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_symbol,
  input  rdsm_pkg::dp_cmd_t     cmd,
  output rdsm_pkg::dp_status_t  status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_matched,
  output logic                  out_bad_pattern
);

  localparam int LW = $clog2(MaxPattern + 1);
  localparam int AW = $clog2(MaxPattern);

  logic [7:0]        store_r [MaxPattern];
  logic [LW-1:0]     len_r, len_nxt;
  logic              last_star_r, last_star_nxt;
  logic              err_r, err_nxt;
  logic [MaxPattern:0] row_r, row_nxt;
  logic [7:0]        byte_r;
  logic              out_valid_r, out_valid_nxt;
  logic              matched_r, bad_r;

  logic [MaxPattern-1:0] pos_valid;
  logic [MaxPattern-1:0] star_at;
  logic [MaxPattern:0]   row_step;
  logic [MaxPattern:0]   row_text;
  logic                  store_full;
  logic                  append_bad;
  logic                  append_ok;

  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      pos_valid[i] = (LW'(i) < len_r);
      star_at[i]   = pos_valid[i] && (store_r[i] == rdsm_pkg::SYM_STAR);
    end
  end

  // one closure pass: a star pair may be skipped
  always_comb begin
    row_step[0] = row_r[0];
    row_step[1] = row_r[1];
    for (int j = 2; j <= MaxPattern; j++) begin
      row_step[j] = row_r[j] | (star_at[j-1] & row_r[j-2]);
    end
  end

  // byte update on a closed row; star chains are closed by later passes
  always_comb begin
    row_text[0] = 1'b0;
    row_text[1] = pos_valid[0] && !star_at[0] && row_r[0] &&
                  rdsm_pkg::sym_hits(store_r[0], byte_r);
    for (int j = 2; j <= MaxPattern; j++) begin
      if (!pos_valid[j-1]) begin
        row_text[j] = 1'b0;
      end else if (star_at[j-1]) begin
        row_text[j] = row_r[j] && rdsm_pkg::sym_hits(store_r[j-2], byte_r);
      end else begin
        row_text[j] = row_r[j-1] && rdsm_pkg::sym_hits(store_r[j-1], byte_r);
      end
    end
  end

  assign store_full = (len_r == LW'(MaxPattern));
  assign append_bad = store_full ||
                      ((in_symbol == rdsm_pkg::SYM_STAR) && ((len_r == '0) || last_star_r));
  assign append_ok  = cmd.append && !append_bad;

  always_comb begin
    len_nxt       = len_r;
    last_star_nxt = last_star_r;
    err_nxt       = err_r;
    row_nxt       = row_r;
    if (cmd.clear) begin
      len_nxt       = '0;
      last_star_nxt = 1'b0;
      err_nxt       = 1'b0;
      row_nxt       = {{MaxPattern{1'b0}}, 1'b1};
    end else if (cmd.append) begin
      row_nxt = {{MaxPattern{1'b0}}, 1'b1};
      if (append_bad) begin
        err_nxt = 1'b1;
      end else begin
        len_nxt       = len_r + 1'b1;
        last_star_nxt = (in_symbol == rdsm_pkg::SYM_STAR);
      end
    end else if (cmd.text) begin
      row_nxt = row_text;
    end else if (cmd.finish) begin
      row_nxt = {{MaxPattern{1'b0}}, 1'b1};
    end else if (cmd.step) begin
      row_nxt = row_step;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      last_star_r <= 1'b0;
      err_r       <= 1'b0;
      row_r       <= {{MaxPattern{1'b0}}, 1'b1};
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      last_star_r <= last_star_nxt;
      err_r       <= err_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (append_ok) begin
      store_r[len_r[AW-1:0]] <= in_symbol;
    end
    if (cmd.capture) begin
      byte_r <= in_symbol;
    end
    if (cmd.finish) begin
      matched_r <= !err_r && row_r[len_r];
      bad_r     <= err_r;
    end
  end

  assign status.stable   = (row_step == row_r);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_matched     = matched_r;
  assign out_bad_pattern = bad_r;

endmodule

FILE: rtl/regex_dot_star_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regex_dot_star_matcher_unit
// streaming matcher for patterns with '.' and 'x*' over byte strings
// ----------------------------------------------------------------------------
// usage:
//   in_req carries action and symbol: clear pattern, append a pattern symbol,
//   a text byte, or end of string. only end of string returns a result on
//   out_res (matched, bad_pattern); the other actions return nothing.
// timing:
//   clear and append act as they are taken. a text byte or end of string is
//   captured and blocks new requests while the match row gets star-closure
//   passes until stable, as many as the longest chain of star pairs the row
//   has to ripple through; then the byte updates the row, or the result is
//   registered and shown on out_res when end of string completes.
// reset:
//   rst_n (synchronous) empties the pattern, clears the bad-pattern flag
//   and restarts the match row; the pattern store itself is not cleared.
// stall:
//   a result waits in the output register while out_res.ready is low; the
//   block keeps taking requests, and only holds a following end of string
//   until that register is free.
// ----------------------------------------------------------------------------
`include "regex_dot_star_matcher_unit_macros.svh"

module regex_dot_star_matcher_unit #(
  parameter int MaxPattern = rdsm_pkg::MAX_PATTERN
) (
  input logic        clk,
  input logic        rst_n,
  rdsm_in_if.sink    in_req,
  rdsm_out_if.source out_res
);

  rdsm_pkg::dp_cmd_t    cmd;
  rdsm_pkg::dp_status_t status;

  rdsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_action (in_req.action),
    .in_ready  (in_req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rdsm_datapath #(
    .MaxPattern (MaxPattern)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_symbol       (in_req.symbol),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (out_res.ready),
    .out_valid       (out_res.valid),
    .out_matched     (out_res.matched),
    .out_bad_pattern (out_res.bad_pattern)
  );

  `RDSM_ASSERT(a_one_cmd, clk, rst_n, $onehot0({cmd.clear, cmd.append, cmd.capture, cmd.step, cmd.text, cmd.finish}), "more than one datapath command")
  `RDSM_ASSERT(a_no_overwrite, clk, rst_n, !cmd.finish || !out_res.valid || out_res.ready, "result overwritten")
  `RDSM_ASSERT(a_result_source, clk, rst_n, !$rose(out_res.valid) || $past(cmd.finish), "result without end of string")
  `RDSM_ASSERT_NEXT(a_busy_after_text, clk, rst_n, in_req.valid && in_req.ready && in_req.action[1], !in_req.ready, "request taken during closure")

endmodule
